// ===== hw/rtl/bin_packing_first_or_best_fit_defines.svh =====
// ----------------------------------------------------------------------------
// Bin packing assertion macros
// Assertion macros for the bin packing checker.
// ----------------------------------------------------------------------------
`ifndef BIN_PACKING_FIRST_OR_BEST_FIT_DEFINES_SVH
`define BIN_PACKING_FIRST_OR_BEST_FIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define BPFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define BPFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpff_pkg.sv =====
// ----------------------------------------------------------------------------
// Bin packing package
// Sizes, word types, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bpff_pkg;

  localparam int MAX_BINS  = 64;
  localparam int BIN_IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W     = $clog2(MAX_BINS + 1);

  localparam int SIZE_W        = 16;
  localparam int CAP_W         = 16;
  localparam int FILL_W        = 17;
  localparam int BIN_INDEX_W   = 6;
  localparam int BINS_IN_USE_W = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd100;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] item_size;
  } in_word_t;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0]   bin_index;
    logic                     opened_new;
    logic                     table_full;
    logic [BINS_IN_USE_W-1:0] bins_in_use;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic issue_rd;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpff_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpff_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bin packing controller
// Sequences acceptance, the fill scan, write-back and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpff_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  output      logic                out_valid,
  input  wire logic                out_stall,
  input  wire bpff_pkg::dp_status_t status,
  output      bpff_pkg::dp_cmd_t    cmd
);

  bpff_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The result register can be reloaded when empty or when it drains now.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpff_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bpff_pkg::ST_SCAN;
        end
      end
      bpff_pkg::ST_SCAN: begin
        if (status.count_zero) begin
          state_nxt = bpff_pkg::ST_WRITE;
        end else if (status.scan_last) begin
          state_nxt = bpff_pkg::ST_DRAIN;
        end
      end
      bpff_pkg::ST_DRAIN: begin
        state_nxt = bpff_pkg::ST_WRITE;
      end
      bpff_pkg::ST_WRITE: begin
        if (out_free) begin
          state_nxt = bpff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpff_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      bpff_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      bpff_pkg::ST_SCAN: begin
        cmd.issue_rd = !status.count_zero;
      end
      bpff_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      bpff_pkg::ST_WRITE: begin
        cmd.commit = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpff_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bpff_dp.sv =====
// ----------------------------------------------------------------------------
// Bin packing datapath
// Configuration, bin fill memory, fit evaluation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpff_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [bpff_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bpff_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire bpff_pkg::in_word_t                   in_word,
  output      bpff_pkg::out_word_t                  out_word,
  input  wire bpff_pkg::dp_cmd_t                    cmd,
  output      bpff_pkg::dp_status_t                 status
);

  localparam int IW = bpff_pkg::BIN_IDX_W;
  localparam int CW = bpff_pkg::CNT_W;
  localparam int FW = bpff_pkg::FILL_W;
  localparam int SW = bpff_pkg::SIZE_W;
  localparam int AW = bpff_pkg::CAP_W;

  logic [AW-1:0] cap_r;
  logic          mode_r;

  logic [SW-1:0] item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] addr_r;
  logic          rd_valid_r;
  logic [IW-1:0] rd_idx_r;
  logic          found_r;
  logic [IW-1:0] best_idx_r;
  logic [AW-1:0] best_room_r;
  logic [FW-1:0] best_fill_r;
  bpff_pkg::out_word_t out_r;

  logic [FW-1:0] rd_fill;
  logic [FW:0]   fit_sum;
  logic          fits;
  logic [AW-1:0] room;
  logic          take;

  logic          can_open;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [FW-1:0] wr_data;
  logic [IW-1:0] chosen;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= bpff_pkg::CAPACITY_RESET;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpff_pkg::CFG_CAPACITY: cap_r  <= cfg_wdata[AW-1:0];
        bpff_pkg::CFG_FIT_MODE: mode_r <= cfg_wdata[0];
        default: begin
          cap_r <= cap_r;
        end
      endcase
    end
  end

  bpff_ram #(
    .WIDTH (FW),
    .DEPTH (bpff_pkg::MAX_BINS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.issue_rd),
    .raddr (addr_r),
    .rdata (rd_fill)
  );

  // Fit test without wrap, and the room left before placing the item.
  assign fit_sum = {1'b0, rd_fill} + (FW+1)'(item_r);
  assign fits    = fit_sum <= (FW+1)'(cap_r);
  assign room    = cap_r - rd_fill[AW-1:0];
  assign take    = rd_valid_r && fits && (!found_r || (mode_r && (room < best_room_r)));

  assign can_open = count_r < CW'(bpff_pkg::MAX_BINS);
  assign wr_en    = cmd.commit && (found_r || can_open);
  assign wr_addr  = found_r ? best_idx_r : count_r[IW-1:0];
  assign wr_data  = found_r ? (best_fill_r + FW'(item_r)) : FW'(item_r);
  assign chosen   = found_r ? best_idx_r : (can_open ? count_r[IW-1:0] : '0);

  always_comb begin
    count_nxt = count_r;
    if (cmd.start && in_word.action) begin
      count_nxt = '0;
    end else if (cmd.commit && !found_r && can_open) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rd_valid_r <= 1'b0;
      found_r    <= 1'b0;
      addr_r     <= '0;
    end else begin
      count_r    <= count_nxt;
      rd_valid_r <= cmd.issue_rd;
      if (cmd.start) begin
        found_r <= 1'b0;
        addr_r  <= '0;
      end else begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (cmd.issue_rd) begin
          addr_r <= addr_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_word.item_size;
    end
    rd_idx_r <= addr_r;
    if (take) begin
      best_idx_r  <= rd_idx_r;
      best_room_r <= room;
      best_fill_r <= rd_fill;
    end
    if (cmd.commit) begin
      out_r.bin_index   <= bpff_pkg::BIN_INDEX_W'(32'(chosen));
      out_r.opened_new  <= !found_r && can_open;
      out_r.table_full  <= !found_r && !can_open;
      out_r.bins_in_use <= bpff_pkg::BINS_IN_USE_W'(32'(count_nxt));
    end
  end

  assign status.count_zero = count_r == '0;
  assign status.scan_last  = CW'(addr_r) == (count_r - CW'(1));
  assign out_word          = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bin_packing_first_or_best_fit.sv =====
// Each accepted word is scanned against the open bins and then written back, which registers its result;
// the next word is taken only once the controller has returned to idle.
// The fill scan reads one bin per cycle through the single read port of the fill memory.
// A new word is taken while the previous result still waits in the output register.
// Reset is synchronous, active low: open count, mode and capacity (100) are restored.
// Bin fill memory is not cleared; only bins below the open count are ever read.
// ----------------------------------------------------------------------------
// Online bin packing, first fit or best fit
// Places item sizes into a table of open bins of one shared capacity.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input word carries an item size and an action flag. With the action
// set, the open count is cleared before the item is placed, which starts a new
// set of bins. The controller then walks the open bins in index order, one
// memory read per cycle. The datapath checks every returned fill against the
// capacity and keeps the winning bin: in first-fit mode the first bin that
// fits, in best-fit mode the bin with the least room left, ties going to the
// lower index. After the scan the chosen bin is updated, or a new bin is
// opened holding the item (even an item larger than the capacity), or, when
// every bin is in use, the item is dropped and flagged as table full.
//
// The result lands in an output register, so the input side is free again as
// soon as the write-back is done; the controller only waits at write-back
// when the previous result has not been taken yet.
//
// Configuration (capacity and fit mode) is written through a plain write
// port and must only change while the block is idle.

module bin_packing_first_or_best_fit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bpff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpff_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire bpff_pkg::in_word_t              in_word,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      bpff_pkg::out_word_t             out_word
);

  bpff_pkg::dp_cmd_t    cmd;
  bpff_pkg::dp_status_t status;

  // Controller: owns the sequence and the result valid flag.
  bpff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: configuration, fill memory, fit evaluation and result payload.
  bpff_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_word  (out_word),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bpff_checker.sv =====
// ----------------------------------------------------------------------------
// Bin packing checker
// Port-level assertions on the bin packing block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bin_packing_first_or_best_fit_defines.svh"

module bpff_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bpff_pkg::out_word_t out_word
);

  // A stalled result holds its word.
  `BPFF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

  // A dropped item reports bin zero and no new bin.
  `BPFF_ASSERT_NOW(a_drop_word, out_valid && out_word.table_full, (out_word.bin_index == '0) && !out_word.opened_new, "dropped item reports a bin")

  // Opening a bin and dropping an item exclude each other.
  `BPFF_ASSERT_NOW(a_open_xor_full, out_valid, !(out_word.opened_new && out_word.table_full), "opened and full together")

  // The block works on one word at a time after taking it.
  `BPFF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken while busy")

endmodule

bind bin_packing_first_or_best_fit bpff_checker u_bpff_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bin packing testbench
// Drives item words into the first-fit / best-fit bin packer and checks every
// placement word against an in-bench copy of the bin table. A short directed
// sequence covers the corner cases, then random sets of items run under
// several capacity and fit-mode settings, most with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bpff_pkg::*;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // The slowest legal run is about 2000 words, each scanning up to MAX_BINS bins,
  // stretched by the idle patterns; this limit leaves a wide margin.
  localparam int CYCLE_LIMIT  = 1_500_000;
  // One full scan of the table plus write-back, with some slack.
  localparam int DRAIN_CYCLES = MAX_BINS + 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASES       = 6;

  // Bin table mirror: keeps its own fills, open count and settings, computes
  // the placement word for every accepted item and checks the block's words
  // in order against them.
  class bin_table;
    logic [FILL_W-1:0] bin_level [MAX_BINS];
    int unsigned       open_bins;
    logic [CAP_W-1:0]  capacity;
    logic              fit_mode;
    out_word_t         pending_placements [$];
    int                errors;

    function new();
      capacity  = CAPACITY_RESET;
      fit_mode  = FIT_FIRST;
      open_bins = 0;
      errors    = 0;
      foreach (bin_level[i]) bin_level[i] = '0;
    endfunction

    function int pending();
      return pending_placements.size();
    endfunction

    function void note_item(in_word_t w);
      int unsigned chosen, best_room, room, level, size, cap, j;
      bit          found, opened, full;
      out_word_t   placement;
      size      = w.item_size;
      cap       = capacity;
      chosen    = 0;
      best_room = 0;
      found     = 1'b0;
      opened    = 1'b0;
      full      = 1'b0;
      if (w.action) open_bins = 0;
      for (j = 0; j < open_bins; j++) begin
        level = bin_level[j];
        if (level + size <= cap) begin
          room = cap - level;
          if (fit_mode == FIT_FIRST) begin
            if (!found) begin
              chosen = j;
              found  = 1'b1;
            end
          end else if (!found || room < best_room) begin
            best_room = room;
            chosen    = j;
            found     = 1'b1;
          end
        end
      end
      if (found) begin
        bin_level[chosen] = bin_level[chosen] + w.item_size;
      end else if (open_bins < MAX_BINS) begin
        chosen            = open_bins;
        bin_level[chosen] = w.item_size;
        open_bins++;
        opened = 1'b1;
      end else begin
        chosen = 0;
        full   = 1'b1;
      end
      placement.bin_index   = chosen[BIN_INDEX_W-1:0];
      placement.opened_new  = opened;
      placement.table_full  = full;
      placement.bins_in_use = open_bins[BINS_IN_USE_W-1:0];
      pending_placements.insert(pending_placements.size(), placement);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_placement(out_word_t got);
      out_word_t want;
      if (pending_placements.size() == 0) begin
        report($sformatf("placement word %h with no item waiting", got));
        return;
      end
      want = pending_placements.pop_front();
      if (got.bin_index !== want.bin_index)
        report($sformatf("bin_index %0d, expected %0d", got.bin_index, want.bin_index));
      if (got.opened_new !== want.opened_new)
        report($sformatf("opened_new %b, expected %b", got.opened_new, want.opened_new));
      if (got.table_full !== want.table_full)
        report($sformatf("table_full %b, expected %b", got.table_full, want.table_full));
      if (got.bins_in_use !== want.bins_in_use)
        report($sformatf("bins_in_use %0d, expected %0d", got.bins_in_use,
                         want.bins_in_use));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;

  // Idle rates in percent of cycles for the sending and receiving sides.
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int cycles;

  bin_table mirror = new();

  bin_packing_first_or_best_fit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiving side. The stall is chosen at the falling edge, and a word is
  // taken at the rising edge when valid is high and the stall is low.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      @(posedge clk);
      if (out_valid && !out_stall) mirror.check_placement(out_word);
    end
  end

  // Offers one item word, idling first at the sender's rate, and holds it
  // until it is accepted. Starts and returns at a falling edge.
  task automatic send_item(input logic act, input logic [SIZE_W-1:0] size);
    in_word_t w;
    w.action    = act;
    w.item_size = size;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    mirror.note_item(w);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every placement has come back,
  // which leaves the block idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  // Writes capacity, then fit mode, in back-to-back cycles. The unused
  // upper bits of the mode write are random and must be ignored.
  task automatic write_settings(input logic [CAP_W-1:0] cap, input logic mode);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_index <= CFG_FIT_MODE;
    cfg_wdata <= {15'($urandom_range(0, 32767)), mode};
    @(negedge clk);
    cfg_we          <= 1'b0;
    mirror.capacity = cap;
    mirror.fit_mode = mode;
  endtask

  // Item sizes spread around the capacity: empty items, the largest size, random
  // sizes, oversized items just above the capacity, and fitting sizes of all kinds.
  function automatic logic [SIZE_W-1:0] pick_size(int unsigned cap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 14) return '1;
    if (r < 24) return SIZE_W'($urandom);
    if (r < 34) return (cap > 65515) ? SIZE_W'($urandom)
                                     : SIZE_W'(cap + $urandom_range(1, 20));
    if (r < 60) return SIZE_W'($urandom_range(0, cap));
    return SIZE_W'($urandom_range(0, cap / 3));
  endfunction

  // Random sets: each starts with a clearing word and then places items.
  // Long sets run the table full; a few stray clearing words break sets up.
  task automatic run_sets(input int count);
    int left, len, k;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 40);
      if (len > left) len = left;
      send_item(1'b1, pick_size(mirror.capacity));
      for (k = 1; k < len; k++)
        send_item($urandom_range(0, 99) < 3, pick_size(mirror.capacity));
      left -= len;
    end
  endtask

  initial begin
    int          p;
    int unsigned cap;
    logic        mode;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, first fit with capacity 100. An oversized item opens
    // its own bin, a zero-size item still fits a bin filled to the brim,
    // and the overfilled bin never takes anything again.
    send_item(1'b1, 16'd30);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'd0);
    send_item(1'b0, 16'd70);
    send_item(1'b0, 16'd0);
    send_item(1'b0, 16'd50);
    send_item(1'b0, 16'd101);
    send_item(1'b0, 16'd40);
    send_item(1'b0, 16'd10);

    // Best fit: the tighter bin wins, and an item that fills a bin to the brim still fits.
    wait_drained();
    write_settings(16'd100, FIT_BEST);
    send_item(1'b1, 16'd60);
    send_item(1'b0, 16'd50);
    send_item(1'b0, 16'd30);
    send_item(1'b0, 16'd20);
    send_item(1'b0, 16'd10);
    send_item(1'b1, 16'd50);
    send_item(1'b0, 16'd50);
    send_item(1'b0, 16'd10);

    // Largest capacity: an item of the full size fills a bin exactly, and
    // the sum of two full-size items must not wrap into a fit.
    wait_drained();
    write_settings(16'hFFFF, FIT_FIRST);
    send_item(1'b1, 16'hFFFF);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'd0);
    send_item(1'b0, 16'd1);

    // Zero capacity: only empty items fit an existing empty bin.
    wait_drained();
    write_settings(16'd0, FIT_BEST);
    send_item(1'b1, 16'd0);
    send_item(1'b0, 16'd0);
    send_item(1'b0, 16'd1);
    send_item(1'b0, 16'd0);

    // Random phases. The first two idle the sender lightly and the receiver
    // heavily, the next two the other way round, the last two not at all.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          cap  = 100;
          mode = FIT_FIRST;
        end
        1: begin
          cap  = 1;
          mode = FIT_BEST;
        end
        2: begin
          cap  = 65535;
          mode = FIT_BEST;
        end
        3: begin
          cap  = 0;
          mode = FIT_FIRST;
        end
        4: begin
          cap  = $urandom_range(2, 1000);
          mode = FIT_BEST;
        end
        default: begin
          cap  = $urandom_range(1, 65535);
          mode = FIT_FIRST;
        end
      endcase
      wait_drained();
      if (p < 2) begin
        in_idle_pct  = 13;
        out_idle_pct = 84;
      end else if (p < 4) begin
        in_idle_pct  = 84;
        out_idle_pct = 13;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_settings(CAP_W'(cap), mode);
      run_sets(RANDOM_ITEMS / PHASES);
    end

    // Let the last word drain, then watch a little longer for stray words.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
